// ===== rtl/cpd_pkg.sv =====
// shared types and constants for the circling phase detector
`default_nettype none
package cpd_pkg;

   // phase codes
   typedef enum logic [1:0] {
      MODE_CRUISE      = 2'd0,
      MODE_POSS_CLIMB  = 2'd1,
      MODE_CLIMB       = 2'd2,
      MODE_POSS_CRUISE = 2'd3
   } mode_type;

   // register indexes
   localparam logic [2:0] REG_MIN_TURN   = 3'd0;
   localparam logic [2:0] REG_CLIMB_CONF = 3'd1;
   localparam logic [2:0] REG_CRUISE_CONF = 3'd2;
   localparam logic [2:0] REG_SWITCH_EN  = 3'd3;
   localparam logic [2:0] REG_SMOOTH     = 3'd4;

   // switch codes
   localparam logic [1:0] SW_CIRCLING = 2'd1;
   localparam logic [1:0] SW_CRUISE   = 2'd2;

   localparam int RateSat   = 65535;
   localparam int RateClamp = 12800;

   // controller state
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_TRK,
      ST_DIV_HDG,
      ST_FILTER,
      ST_PHASE,
      ST_OUT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;       // capture item, clear rates when they cannot be computed
      logic div_start;  // start a division
      logic div_sel;    // 0 track, 1 heading
      logic filter;     // update filter
      logic phase;      // run phase machine and commit
      logic out_load;   // load output register
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic div_busy;
      logic need_div;   // rates must be divided
   } sts_type;

endpackage
`default_nettype wire

// ===== rtl/circling_phase_detector.sv =====
// Circling phase detector top level.
// One navigation fix enters on the req_ stream; one result leaves on rsp_.
// Configuration registers must be written through the csr_ channel only
// while idle; the user is bound by this, as the block does not enforce it.
// Each fix runs: capture, two 48-step serial divisions for track and
// heading rate (shared divider) when rates must be divided, filter update,
// phase update, output load. A new fix is accepted only after the last
// one has been loaded into the output register.
// The output register holds the result while the receiver stalls; a new
// item is taken in the meantime and waits only at the output load.
// Reset zeroes persistent state, mode cruise, registers to their defaults.
// req_tdata fields from bit 0: time_valid, flying, sample_time_ms,
// track_angle, heading_angle, replay, switch_mode, latitude, longitude,
// nav_alt, energy_ht, zero fill.
`default_nettype none
module circling_phase_detector (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [167:0] req_tdata,  // time_valid..energy_ht, low bit up
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [167:0]      rsp_tdata,  // track_rate..phase_start_altitude
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [19:0]  csr_data
);
   cpd_pkg::cmd_type cmd;
   cpd_pkg::sts_type sts;
   logic in_fire;

   assign in_fire   = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   cpd_controller u_ctl (
      .clock(clock), .reset(reset), .in_fire(in_fire), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .cmd(cmd), .sts(sts)
   );

   cpd_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .in_data(req_tdata[160:0]), .csr_index(csr_index), .csr_data(csr_data),
      .csr_we(csr_valid), .out_data(rsp_tdata)
   );
endmodule
`default_nettype wire

// ===== rtl/cpd_divider.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none
module cpd_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [47:0] num,
   input  wire logic [47:0] den,
   output logic             busy,
   output logic [47:0]      quo
);
   logic [47:0] rem_ff, rem_in, quo_ff, quo_in, den_ff;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [48:0] trial;

   // one shift and subtract step
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, quo_ff[47]} - {1'b0, den_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         cnt_in  = 6'd48;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[48]) begin
            rem_in = trial[47:0];
            quo_in = {quo_ff[46:0], 1'b1};
         end else begin
            rem_in = {rem_ff[46:0], quo_ff[47]};
            quo_in = {quo_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) den_ff <= den;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;
endmodule
`default_nettype wire

// ===== rtl/cpd_datapath.sv =====
// rate, filter, phase state and output register
`default_nettype none
module cpd_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cpd_pkg::cmd_type    cmd,
   output cpd_pkg::sts_type         sts,
   input  wire logic [160:0]        in_data,
   input  wire logic [2:0]          csr_index,
   input  wire logic [19:0]         csr_data,
   input  wire logic                csr_we,
   output logic [167:0]             out_data
);
   // configuration
   logic [13:0] min_turn_ff;
   logic [19:0] climb_conf_ff, cruise_conf_ff;
   logic        sw_en_ff;
   logic [8:0]  smooth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_turn_ff    <= 14'd1024;
         climb_conf_ff  <= 20'd15000;
         cruise_conf_ff <= 20'd10000;
         sw_en_ff       <= 1'b0;
         smooth_ff      <= 9'd77;
      end else if (csr_we) begin
         unique case (csr_index)
            cpd_pkg::REG_MIN_TURN:    min_turn_ff    <= csr_data[13:0];
            cpd_pkg::REG_CLIMB_CONF:  climb_conf_ff  <= csr_data;
            cpd_pkg::REG_CRUISE_CONF: cruise_conf_ff <= csr_data;
            cpd_pkg::REG_SWITCH_EN:   sw_en_ff       <= csr_data[0];
            cpd_pkg::REG_SMOOTH:      smooth_ff      <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   // captured item
   logic               tv_ff, fly_ff, replay_ff;
   logic [26:0]        t_ff;
   logic [15:0]        trk_ff, hdg_ff;
   logic [1:0]         sw_ff;
   logic signed [30:0] lat_ff;
   logic signed [31:0] lon_ff;
   logic signed [17:0] nav_ff;
   logic [15:0]        eh_ff;
   logic               adv_ff, zero_ff;
   logic [26:0]        dt_ff;

   // persistent state
   logic [26:0]        prev_t_ff;
   logic               prev_tv_ff;
   logic [15:0]        prev_trk_ff, prev_hdg_ff;
   logic signed [16:0] trk_rate_ff, hdg_rate_ff;
   logic signed [14:0] filt_ff;
   logic               turning_ff, circling_ff;
   cpd_pkg::mode_type  mode_ff;
   logic [26:0]        ts_time_ff, cl_time_ff, cr_time_ff;
   logic signed [30:0] ts_lat_ff, cl_lat_ff, cr_lat_ff;
   logic signed [31:0] ts_lon_ff, cl_lon_ff, cr_lon_ff;
   logic signed [17:0] ts_alt_ff, cr_alt_ff;
   logic [15:0]        ts_eh_ff;
   logic signed [18:0] cl_alt_ff;

   // divider operand selection
   logic [15:0] dsel;
   logic        neg_sel;
   logic [15:0] mag_sel;
   logic [47:0] num, den, quo;
   logic        div_busy;

   always_comb begin
      dsel    = cmd.div_sel ? (hdg_ff - prev_hdg_ff) : (trk_ff - prev_trk_ff);
      neg_sel = dsel > 16'd32768;
      mag_sel = neg_sel ? (16'd0 - dsel) : dsel;
      // q = (2*mag*5625 + 4dt) / (8dt)
      num = 48'(30'(mag_sel) * 30'd11250) + {19'd0, dt_ff, 2'b00};
      den = {18'd0, dt_ff, 3'b000};
   end

   cpd_divider u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .num(num), .den(den), .busy(div_busy), .quo(quo)
   );

   logic neg_ff;
   always_ff @(posedge clock) if (cmd.div_start) neg_ff <= neg_sel;

   logic [16:0]        qsat;
   logic signed [16:0] rate_res;
   always_comb begin
      qsat     = (quo > 48'(cpd_pkg::RateSat)) ? 17'd65535 : quo[16:0];
      rate_res = neg_ff ? -$signed(qsat) : $signed(qsat);
   end

   assign sts.div_busy = div_busy;
   assign sts.need_div = adv_ff && !zero_ff;

   // filter arithmetic
   logic signed [16:0] x;
   logic signed [17:0] diff;
   logic signed [27:0] prod;
   logic signed [19:0] step, ysum;
   logic signed [14:0] ynew;
   logic [14:0]        ymag;
   always_comb begin
      if (trk_rate_ff > 17'sd12800)       x = 17'sd12800;
      else if (trk_rate_ff < -17'sd12800) x = -17'sd12800;
      else                                x = trk_rate_ff;
      diff = 18'(x) - 18'(filt_ff);
      prod = $signed({1'b0, smooth_ff}) * 28'(diff) + 28'sd128;
      step = 20'(prod >>> 8);
      ysum = 20'(filt_ff) + step;
      if (ysum > 20'sd12800)       ynew = 15'sd12800;
      else if (ysum < -20'sd12800) ynew = -15'sd12800;
      else                         ynew = ysum[14:0];
      ymag = ynew[14] ? 15'(-ynew) : ynew;
   end

   // phase machine next values
   logic fc, fcr, trn, upd_ts, to_climb, to_cruise;
   logic [26:0] ts_eff;
   cpd_pkg::mode_type mode_nx;
   always_comb begin
      trn       = turning_ff;
      fc        = sw_en_ff && !replay_ff && sw_ff == cpd_pkg::SW_CIRCLING;
      fcr       = sw_en_ff && !replay_ff && sw_ff == cpd_pkg::SW_CRUISE;
      upd_ts    = 1'b0;
      to_climb  = 1'b0;
      to_cruise = 1'b0;
      mode_nx   = mode_ff;
      ts_eff    = ts_time_ff;
      unique case (mode_ff) inside
         cpd_pkg::MODE_CRUISE, cpd_pkg::MODE_POSS_CLIMB: begin
            if (mode_ff == cpd_pkg::MODE_CRUISE && (trn || fc)) begin
               upd_ts  = 1'b1;
               ts_eff  = t_ff;
               mode_nx = cpd_pkg::MODE_POSS_CLIMB;
            end
            if (mode_ff == cpd_pkg::MODE_POSS_CLIMB || fc) begin
               if (fcr) mode_nx = cpd_pkg::MODE_CRUISE;
               else if (trn || fc) begin
                  if ($signed({1'b0, t_ff}) - $signed({1'b0, ts_eff})
                      > $signed({8'd0, climb_conf_ff}) || fc) begin
                     to_climb = 1'b1;
                     mode_nx  = cpd_pkg::MODE_CLIMB;
                  end
               end else mode_nx = cpd_pkg::MODE_CRUISE;
            end
         end
         default: begin
            if (mode_ff == cpd_pkg::MODE_CLIMB && (!trn || fcr)) begin
               upd_ts  = 1'b1;
               ts_eff  = t_ff;
               mode_nx = cpd_pkg::MODE_POSS_CRUISE;
            end
            if (mode_ff == cpd_pkg::MODE_POSS_CRUISE || fcr) begin
               if (fc) mode_nx = cpd_pkg::MODE_CLIMB;
               else if (!trn || fcr) begin
                  if ($signed({1'b0, t_ff}) - $signed({1'b0, ts_eff})
                      > $signed({8'd0, cruise_conf_ff}) || fcr) begin
                     to_cruise = 1'b1;
                     mode_nx   = cpd_pkg::MODE_CRUISE;
                  end
               end else mode_nx = cpd_pkg::MODE_CLIMB;
            end
         end
      endcase
   end

   // turn start source after possible update
   logic [26:0]        ts_t_n;
   logic signed [30:0] ts_lat_n;
   logic signed [31:0] ts_lon_n;
   logic signed [17:0] ts_alt_n;
   logic [15:0]        ts_eh_n;
   always_comb begin
      ts_t_n   = upd_ts ? t_ff   : ts_time_ff;
      ts_lat_n = upd_ts ? lat_ff : ts_lat_ff;
      ts_lon_n = upd_ts ? lon_ff : ts_lon_ff;
      ts_alt_n = upd_ts ? nav_ff : ts_alt_ff;
      ts_eh_n  = upd_ts ? eh_ff  : ts_eh_ff;
   end

   // detect divider completion per operand
   logic busy_d_ff, sel_d_ff, div_done_trk, div_done_hdg;
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_d_ff <= 1'b0;
         sel_d_ff  <= 1'b0;
      end else begin
         busy_d_ff <= div_busy;
         if (cmd.div_start) sel_d_ff <= cmd.div_sel;
      end
   end
   assign div_done_trk = busy_d_ff && !div_busy && !sel_d_ff;
   assign div_done_hdg = busy_d_ff && !div_busy && sel_d_ff;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_t_ff   <= '0; prev_tv_ff  <= 1'b0;
         prev_trk_ff <= '0; prev_hdg_ff <= '0;
         trk_rate_ff <= '0; hdg_rate_ff <= '0;
         filt_ff     <= '0; turning_ff  <= 1'b0;
         circling_ff <= 1'b0; mode_ff   <= cpd_pkg::MODE_CRUISE;
         ts_time_ff <= '0; ts_lat_ff <= '0; ts_lon_ff <= '0; ts_alt_ff <= '0;
         ts_eh_ff   <= '0;
         cl_time_ff <= '0; cl_lat_ff <= '0; cl_lon_ff <= '0; cl_alt_ff <= '0;
         cr_time_ff <= '0; cr_lat_ff <= '0; cr_lon_ff <= '0; cr_alt_ff <= '0;
      end else begin
         if (cmd.load) begin
            if (!in_data[0] || !prev_tv_ff || !in_data[1]) begin
               trk_rate_ff <= '0;
               hdg_rate_ff <= '0;
            end
         end
         if (cmd.filter && adv_ff && fly_ff) begin
            filt_ff    <= ynew;
            turning_ff <= ymag >= {1'b0, min_turn_ff};
         end
         if (cmd.phase) begin
            if (adv_ff && fly_ff) begin
               mode_ff <= mode_nx;
               if (upd_ts) begin
                  ts_time_ff <= ts_t_n; ts_lat_ff <= ts_lat_n;
                  ts_lon_ff  <= ts_lon_n; ts_alt_ff <= ts_alt_n;
                  ts_eh_ff   <= ts_eh_n;
               end
               if (to_climb) begin
                  circling_ff <= 1'b1;
                  cl_time_ff <= ts_t_n; cl_lat_ff <= ts_lat_n; cl_lon_ff <= ts_lon_n;
                  cl_alt_ff  <= 19'(ts_alt_n) + 19'($signed({1'b0, ts_eh_n}));
               end
               if (to_cruise) begin
                  circling_ff <= 1'b0;
                  cr_time_ff <= ts_t_n; cr_lat_ff <= ts_lat_n; cr_lon_ff <= ts_lon_n;
                  cr_alt_ff  <= ts_alt_n;
               end
            end
            prev_t_ff   <= t_ff;
            prev_tv_ff  <= tv_ff;
            prev_trk_ff <= trk_ff;
            prev_hdg_ff <= hdg_ff;
         end
         // division results land when the divider finishes
         if (div_done_trk) trk_rate_ff <= rate_res;
         if (div_done_hdg) hdg_rate_ff <= rate_res;
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tv_ff     <= in_data[0];
         fly_ff    <= in_data[1];
         t_ff      <= in_data[28:2];
         trk_ff    <= in_data[44:29];
         hdg_ff    <= in_data[60:45];
         replay_ff <= in_data[61];
         sw_ff     <= in_data[63:62];
         lat_ff    <= in_data[94:64];
         lon_ff    <= in_data[126:95];
         nav_ff    <= in_data[144:127];
         eh_ff     <= in_data[160:145];
         adv_ff    <= in_data[0] && prev_tv_ff && (in_data[28:2] > prev_t_ff);
         zero_ff   <= !in_data[0] || !prev_tv_ff || !in_data[1];
         dt_ff     <= in_data[28:2] - prev_t_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_data[16:0]  <= trk_rate_ff;
         out_data[33:17] <= hdg_rate_ff;
         out_data[48:34] <= filt_ff;
         out_data[49]    <= turning_ff;
         out_data[50]    <= circling_ff;
         out_data[52:51] <= mode_ff;
         out_data[79:53] <= circling_ff ? cl_time_ff : cr_time_ff;
         out_data[110:80] <= circling_ff ? cl_lat_ff : cr_lat_ff;
         out_data[142:111] <= circling_ff ? cl_lon_ff : cr_lon_ff;
         out_data[161:143] <= circling_ff ? cl_alt_ff : 19'(cr_alt_ff);
         out_data[167:162] <= '0;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/cpd_controller.sv =====
// sequencing state machine
`default_nettype none
module cpd_controller (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_fire,
   output logic                  in_ready,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output cpd_pkg::cmd_type      cmd,
   input  wire cpd_pkg::sts_type sts
);
   cpd_pkg::state_type state_ff, state_in;
   logic ov_ff, ov_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpd_pkg::ST_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      ov_in    = ov_ff && !out_ready;
      in_ready = 1'b0;
      unique case (state_ff)
         cpd_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            if (in_fire) begin
               cmd.load = 1'b1;
               state_in = cpd_pkg::ST_DIV_TRK;
            end
         end
         cpd_pkg::ST_DIV_TRK: begin
            if (sts.need_div) begin
               cmd.div_start = 1'b1;
               state_in = cpd_pkg::ST_DIV_HDG;
            end else state_in = cpd_pkg::ST_FILTER;
         end
         cpd_pkg::ST_DIV_HDG: begin
            cmd.div_sel = 1'b1;
            if (!sts.div_busy) begin
               cmd.div_start = 1'b1;
               state_in = cpd_pkg::ST_FILTER;
            end
         end
         cpd_pkg::ST_FILTER: begin
            if (!sts.div_busy) begin
               cmd.filter = 1'b1;
               state_in = cpd_pkg::ST_PHASE;
            end
         end
         cpd_pkg::ST_PHASE: begin
            cmd.phase = 1'b1;
            state_in  = cpd_pkg::ST_OUT;
         end
         cpd_pkg::ST_OUT: begin
            if (!ov_ff || out_ready) begin
               cmd.out_load = 1'b1;
               ov_in    = 1'b1;
               state_in = cpd_pkg::ST_IDLE;
            end
         end
         default: state_in = cpd_pkg::ST_IDLE;
      endcase
   end
   assign out_valid = ov_ff;
endmodule
`default_nettype wire
